// ----- hw/rtl/nucleotide_region_masker_unit_defines.svh -----
// assertion macros shared by the region masker rtl
// expects clk and rst_n in the scope of each use
`ifndef NUCLEOTIDE_REGION_MASKER_UNIT_DEFINES_SVH
`define NUCLEOTIDE_REGION_MASKER_UNIT_DEFINES_SVH

// property checked on every clock outside reset
`define NRM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a property in the next
`define NRM_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);

`endif

// ----- hw/rtl/nrm_pkg.sv -----
// shared types and constants of the nucleotide region masker
// no dependencies
package nrm_pkg;

  localparam int NRM_MAX_REGIONS_DEF = 64;

  // item modes
  localparam logic [1:0] MODE_NEW_SEQ = 2'd0;
  localparam logic [1:0] MODE_REGION  = 2'd1;
  localparam logic [1:0] MODE_BYTE    = 2'd2;

  // register byte addresses
  localparam logic [1:0] CFG_ADDR_MASK_WITH_N = 2'd0;

  // characters
  localparam logic [7:0] CH_A_UP = 8'h41;
  localparam logic [7:0] CH_A_LO = 8'h61;
  localparam logic [7:0] CH_C_UP = 8'h43;
  localparam logic [7:0] CH_C_LO = 8'h63;
  localparam logic [7:0] CH_G_UP = 8'h47;
  localparam logic [7:0] CH_G_LO = 8'h67;
  localparam logic [7:0] CH_T_UP = 8'h54;
  localparam logic [7:0] CH_T_LO = 8'h74;
  localparam logic [7:0] CH_N_UP = 8'h4E;
  localparam logic [7:0] CH_N_LO = 8'h6E;
  localparam logic [7:0] CH_Z_UP = 8'h5A;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic [31:0] rstart;
    logic [31:0] rend;
  } nrm_range_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       was_masked;
    logic       region_dropped;
  } nrm_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_SCAN,
    ST_MOVE,
    ST_FILL,
    ST_DONE
  } nrm_state_t;

endpackage

// ----- hw/rtl/nrm_cfg_regs.sv -----
// configuration register file, apb-style write and read
// uses nrm_pkg for the register address
module nrm_cfg_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic        mask_with_n_o
);
  import nrm_pkg::*;

  logic mask_with_n_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready && (paddr == CFG_ADDR_MASK_WITH_N);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_with_n_r <= 1'b0;
    end else if (wr_en) begin
      mask_with_n_r <= pwdata[0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    unique case (paddr)
      CFG_ADDR_MASK_WITH_N: prdata = {31'd0, mask_with_n_r};
      default:              prdata = 32'd0;
    endcase
  end

  assign mask_with_n_o = mask_with_n_r;

endmodule

// ----- hw/rtl/nrm_base_mask.sv -----
// byte classification and masking of one sequence character
// uses nrm_pkg for character codes
module nrm_base_mask (
  input  logic [7:0] byte_i,
  input  logic       covered_i,
  input  logic       mask_with_n_i,
  output logic       is_base_o,
  output logic       is_n_o,
  output logic [7:0] res_byte_o,
  output logic       masked_o
);
  import nrm_pkg::*;

  logic [7:0] masked_byte;
  logic       hit;

  always_comb begin
    is_base_o = 1'b0;
    is_n_o    = 1'b0;
    case (byte_i) inside
      CH_A_UP, CH_A_LO, CH_C_UP, CH_C_LO,
      CH_G_UP, CH_G_LO, CH_T_UP, CH_T_LO: is_base_o = 1'b1;
      CH_N_UP, CH_N_LO:                   is_n_o = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    if (mask_with_n_i) begin
      masked_byte = CH_N_LO;
    end else if (byte_i >= CH_A_UP && byte_i <= CH_Z_UP) begin
      masked_byte = byte_i + CASE_OFFSET;
    end else begin
      masked_byte = byte_i;
    end
  end

  assign hit        = is_base_o && covered_i;
  assign res_byte_o = hit ? masked_byte : byte_i;
  assign masked_o   = hit && (masked_byte != byte_i);

endmodule

// ----- hw/rtl/nrm_engine.sv -----
// range table memory with its sweep, merge-insert and shift sequencer
// uses nrm_pkg, nrm_base_mask and the assertion macro header
`include "nucleotide_region_masker_unit_defines.svh"

module nrm_engine #(
  parameter int MAX_REGIONS = nrm_pkg::NRM_MAX_REGIONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start_i,
  input  logic [1:0]          mode_i,
  input  logic [31:0]         rstart_i,
  input  logic [31:0]         rend_i,
  input  logic [7:0]          byte_i,
  input  logic                mask_with_n_i,
  input  logic                res_free_i,
  output logic                ready_o,
  output logic                done_o,
  output nrm_pkg::nrm_result_t res_o
);
  import nrm_pkg::*;

  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] DEPTH = CW'(MAX_REGIONS);

  nrm_range_t range_mem_r [MAX_REGIONS];
  nrm_range_t rdata_r;
  logic [AW-1:0] raddr, waddr;
  nrm_range_t wdata;
  logic we;

  nrm_state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   pos_r, pos_nxt;
  logic [CW-1:0] sweep_r, sweep_nxt;
  logic          cov_v_r, cov_v_nxt;
  logic [31:0]   cov_until_r, cov_until_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] mv_left_r, mv_left_nxt;

  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic          phase_hi_r, phase_hi_nxt;
  logic [31:0]   ns_r, ns_nxt, ne_r, ne_nxt;
  logic [31:0]   s_r, s_nxt, e_r, e_nxt;
  logic [7:0]    c_r, c_nxt;
  logic [CW-1:0] mv_src_r, mv_src_nxt, mv_dst_r, mv_dst_nxt;
  logic [CW-1:0] pend_addr_r, pend_addr_nxt;
  logic          mv_up_r, mv_up_nxt;
  nrm_result_t   res_r, res_nxt, res_imm;

  // shared conditions
  logic [7:0]    cur_byte;
  logic          covered, is_base, is_n, mb_masked;
  logic [7:0]    mb_byte;
  logic          cache_hit, sweep_in, sweep_hit, end_below_pos, sweep_next_in;
  logic          region_ok, scan_in, scan_skip, scan_take, scan_adv;
  logic          move_dn, full, mv_busy;
  logic [CW-1:0] sweep_inc, idx_inc;
  logic [31:0]   pos_adv;

  assign cur_byte      = (state_r == ST_IDLE) ? byte_i : c_r;
  assign cache_hit     = cov_v_r && (pos_r <= cov_until_r);
  assign sweep_in      = sweep_r < cnt_r;
  assign sweep_inc     = sweep_r + ONE;
  assign sweep_next_in = sweep_inc < cnt_r;
  assign end_below_pos = rdata_r.rend < pos_r;
  assign sweep_hit     = !end_below_pos && (rdata_r.rstart <= pos_r);
  assign covered       = (state_r == ST_IDLE) ? cache_hit : sweep_hit;
  assign region_ok     = rstart_i <= rend_i;
  assign scan_in       = idx_r < cnt_r;
  assign idx_inc       = idx_r + ONE;
  assign scan_skip     = scan_in && (rdata_r.rend < s_r);
  assign scan_take     = scan_in && (rdata_r.rstart <= e_r);
  assign scan_adv      = (!phase_hi_r && scan_skip) || scan_take;
  // merged ranges leave a hole to close only if more than one merged and some follow
  assign move_dn       = ((idx_r - lo_r) != ONE) && scan_in;
  assign full          = cnt_r == DEPTH;
  assign mv_busy       = mv_left_r != '0;
  assign pos_adv       = (pos_r == 32'hFFFF_FFFF) ? pos_r : pos_r + 32'd1;

  nrm_base_mask u_mask (
    .byte_i        (cur_byte),
    .covered_i     (covered),
    .mask_with_n_i (mask_with_n_i),
    .is_base_o     (is_base),
    .is_n_o        (is_n),
    .res_byte_o    (mb_byte),
    .masked_o      (mb_masked)
  );

  // range table, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      range_mem_r[waddr] <= wdata;
    end
    rdata_r <= range_mem_r[raddr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          unique case (mode_i)
            MODE_REGION: if (region_ok) state_nxt = ST_SCAN;
            MODE_BYTE:   if (is_base && !cache_hit && sweep_in) state_nxt = ST_SWEEP;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SWEEP: begin
        if (!(end_below_pos && sweep_next_in)) state_nxt = ST_DONE;
      end
      ST_SCAN: begin
        if (!scan_adv) begin
          if (phase_hi_r) begin
            state_nxt = move_dn ? ST_MOVE : ST_DONE;
          end else begin
            state_nxt = full ? ST_DONE : ST_MOVE;
          end
        end
      end
      ST_MOVE: begin
        if (!mv_busy && !pend_r) state_nxt = mv_up_r ? ST_FILL : ST_DONE;
      end
      ST_FILL: state_nxt = ST_DONE;
      ST_DONE: if (res_free_i) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    sweep_nxt     = sweep_r;
    cov_v_nxt     = cov_v_r;
    cov_until_nxt = cov_until_r;
    pend_nxt      = pend_r;
    mv_left_nxt   = mv_left_r;
    idx_nxt       = idx_r;
    lo_nxt        = lo_r;
    phase_hi_nxt  = phase_hi_r;
    ns_nxt        = ns_r;
    ne_nxt        = ne_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    c_nxt         = c_r;
    mv_src_nxt    = mv_src_r;
    mv_dst_nxt    = mv_dst_r;
    pend_addr_nxt = pend_addr_r;
    mv_up_nxt     = mv_up_r;
    res_nxt       = res_r;
    res_imm       = '0;
    raddr         = sweep_r[AW-1:0];
    waddr         = lo_r[AW-1:0];
    wdata         = rdata_r;
    we            = 1'b0;
    done_o        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          s_nxt = rstart_i;
          e_nxt = rend_i;
          c_nxt = byte_i;
          unique case (mode_i)
            MODE_NEW_SEQ: begin
              cnt_nxt       = '0;
              pos_nxt       = '0;
              sweep_nxt     = '0;
              cov_v_nxt     = 1'b0;
              cov_until_nxt = '0;
              done_o        = 1'b1;
            end
            MODE_REGION: begin
              idx_nxt      = '0;
              phase_hi_nxt = 1'b0;
              raddr        = '0;
              done_o       = !region_ok;
            end
            MODE_BYTE: begin
              res_imm.out_byte   = mb_byte;
              res_imm.was_masked = mb_masked;
              if (is_base) begin
                if (!cache_hit) cov_v_nxt = 1'b0;
                if (cache_hit || !sweep_in) begin
                  pos_nxt = pos_adv;
                  done_o  = 1'b1;
                end
              end else begin
                if (is_n) pos_nxt = pos_adv;
                done_o = 1'b1;
              end
            end
            default: done_o = 1'b1;
          endcase
        end
      end
      ST_SWEEP: begin
        if (end_below_pos) begin
          sweep_nxt = sweep_inc;
          raddr     = sweep_inc[AW-1:0];
        end else if (sweep_hit) begin
          cov_v_nxt     = 1'b1;
          cov_until_nxt = rdata_r.rend;
        end
        if (!(end_below_pos && sweep_next_in)) begin
          pos_nxt                = pos_adv;
          res_nxt.out_byte       = mb_byte;
          res_nxt.was_masked     = mb_masked;
          res_nxt.region_dropped = 1'b0;
        end
      end
      ST_SCAN: begin
        res_nxt = '0;
        if (!phase_hi_r && scan_skip) begin
          idx_nxt = idx_inc;
          raddr   = idx_inc[AW-1:0];
        end else if (scan_take) begin
          if (!phase_hi_r) begin
            lo_nxt       = idx_r;
            ns_nxt       = (rdata_r.rstart < s_r) ? rdata_r.rstart : s_r;
            phase_hi_nxt = 1'b1;
          end
          ne_nxt  = (rdata_r.rend > e_r) ? rdata_r.rend : e_r;
          idx_nxt = idx_inc;
          raddr   = idx_inc[AW-1:0];
        end else if (phase_hi_r) begin
          // merge into the entry at lo, then close the gap
          we            = 1'b1;
          waddr         = lo_r[AW-1:0];
          wdata.rstart  = ns_r;
          wdata.rend    = ne_r;
          cnt_nxt       = cnt_r - (idx_r - lo_r - ONE);
          sweep_nxt     = '0;
          cov_v_nxt     = 1'b0;
          cov_until_nxt = '0;
          mv_up_nxt     = 1'b0;
          mv_src_nxt    = idx_r;
          mv_dst_nxt    = lo_r + ONE;
          mv_left_nxt   = cnt_r - idx_r;
          pend_nxt      = 1'b0;
        end else if (full) begin
          res_nxt.region_dropped = 1'b1;
        end else begin
          // open a slot at lo by shifting the tail up one entry
          lo_nxt        = idx_r;
          cnt_nxt       = cnt_r + ONE;
          sweep_nxt     = '0;
          cov_v_nxt     = 1'b0;
          cov_until_nxt = '0;
          mv_up_nxt     = 1'b1;
          mv_src_nxt    = cnt_r - ONE;
          mv_dst_nxt    = cnt_r;
          mv_left_nxt   = cnt_r - idx_r;
          pend_nxt      = 1'b0;
        end
      end
      ST_MOVE: begin
        if (pend_r) begin
          we    = 1'b1;
          waddr = pend_addr_r[AW-1:0];
          wdata = rdata_r;
        end
        if (mv_busy) begin
          raddr         = mv_src_r[AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = mv_dst_r;
          mv_left_nxt   = mv_left_r - ONE;
          mv_src_nxt    = mv_up_r ? mv_src_r - ONE : mv_src_r + ONE;
          mv_dst_nxt    = mv_up_r ? mv_dst_r - ONE : mv_dst_r + ONE;
        end else begin
          pend_nxt = 1'b0;
        end
      end
      ST_FILL: begin
        we           = 1'b1;
        waddr        = lo_r[AW-1:0];
        wdata.rstart = s_r;
        wdata.rend   = e_r;
      end
      ST_DONE: done_o = res_free_i;
      default: ;
    endcase
  end

  assign ready_o = (state_r == ST_IDLE) && res_free_i;
  assign res_o   = (state_r == ST_DONE) ? res_r : res_imm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pos_r       <= '0;
      sweep_r     <= '0;
      cov_v_r     <= 1'b0;
      cov_until_r <= '0;
      pend_r      <= 1'b0;
      mv_left_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      sweep_r     <= sweep_nxt;
      cov_v_r     <= cov_v_nxt;
      cov_until_r <= cov_until_nxt;
      pend_r      <= pend_nxt;
      mv_left_r   <= mv_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    lo_r        <= lo_nxt;
    phase_hi_r  <= phase_hi_nxt;
    ns_r        <= ns_nxt;
    ne_r        <= ne_nxt;
    s_r         <= s_nxt;
    e_r         <= e_nxt;
    c_r         <= c_nxt;
    mv_src_r    <= mv_src_nxt;
    mv_dst_r    <= mv_dst_nxt;
    pend_addr_r <= pend_addr_nxt;
    mv_up_r     <= mv_up_nxt;
    res_r       <= res_nxt;
  end

  `NRM_ASSERT(a_cnt_bound, cnt_r <= DEPTH, "range count above table depth")
  `NRM_ASSERT(a_cache_in_table, cov_v_r |-> (sweep_r < cnt_r), "cached range outside table")
  `NRM_ASSERT(a_sweep_in_table, (state_r == ST_SWEEP) |-> (sweep_r < cnt_r), "sweep reads past table")
  `NRM_ASSERT(a_move_in_table, (state_r == ST_MOVE && pend_r) |-> (pend_addr_r < cnt_r), "shift writes past table")
  `NRM_ASSERT_NEXT(a_done_holds, state_r == ST_DONE && !res_free_i, state_r == ST_DONE, "result left before taken")

endmodule

// ----- hw/rtl/nucleotide_region_masker_unit.sv -----
// top level of the nucleotide region masker
// uses nrm_pkg, nrm_cfg_regs, nrm_engine
//
// Masks a DNA byte stream by base-position ranges held in a sorted, merged
// range table (one synchronous memory, one read and one write per cycle).
// Items are taken one at a time. A new-sequence item, an unused mode, a
// non-base byte, a base whose position lies in the cached covering range, a
// base whose sweep pointer is already past the table, and a reversed region
// each finish straight from the idle state. A base that misses the cache walks
// the table from the sweep pointer through the registered read of the table,
// skipping ranges that end below its position, until it reaches a range that
// does not or runs off the end of the table. A region load scans the table
// from the start at one entry per cycle up to the last overlapped range or the
// insertion point, then shifts the tail entries one per cycle through the
// single memory port (up by one for an insert, down to close the gap after a
// multi-range merge); an insert then writes the new range into the opened
// slot. A merge with nothing to shift and a dropped region skip the shift.
// Items that end through the done state wait there while the result register
// is stalled. Results leave through an output register, so the next item is
// taken while a result waits, unless it is still stalled. The table needs no
// clearing pass: only entries below the range count are read.
module nucleotide_region_masker_unit #(
  parameter int MAX_REGIONS = nrm_pkg::NRM_MAX_REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_region_start,
  input  logic [31:0] in_region_end,
  input  logic [7:0]  in_in_byte,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_byte,
  output logic        out_was_masked,
  output logic        out_region_dropped,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import nrm_pkg::*;

  logic        mask_with_n;
  logic        eng_ready;
  logic        eng_done;
  logic        accept;
  logic        res_free;
  nrm_result_t eng_res;

  logic        out_valid_r;
  nrm_result_t out_res_r;

  nrm_cfg_regs u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .mask_with_n_o (mask_with_n)
  );

  // output register is free when empty or being taken this cycle
  assign res_free = !out_valid_r || !out_stall;
  assign in_stall = !eng_ready;
  assign accept   = in_valid && eng_ready;

  nrm_engine #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .start_i       (accept),
    .mode_i        (in_mode),
    .rstart_i      (in_region_start),
    .rend_i        (in_region_end),
    .byte_i        (in_in_byte),
    .mask_with_n_i (mask_with_n),
    .res_free_i    (res_free),
    .ready_o       (eng_ready),
    .done_o        (eng_done),
    .res_o         (eng_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (eng_done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done) begin
      out_res_r <= eng_res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_out_byte       = out_res_r.out_byte;
  assign out_was_masked     = out_res_r.was_masked;
  assign out_region_dropped = out_res_r.region_dropped;

endmodule

// ----- test/nrm_mask_checker.sv -----
`timescale 1ns / 100ps
// scoreboard for the nucleotide region masker: keeps its own range table,
// predicts each result item from the accepted input items; uses nrm_pkg
module nrm_mask_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_region_start,
  input  logic [31:0] in_region_end,
  input  logic [7:0]  in_in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_out_byte,
  input  logic        out_was_masked,
  input  logic        out_region_dropped,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);
  import nrm_pkg::*;

  localparam int TABLE_DEPTH = NRM_MAX_REGIONS_DEF;

  logic [31:0] tbl_start [TABLE_DEPTH];
  logic [31:0] tbl_end   [TABLE_DEPTH];
  int          tbl_count;
  logic [31:0] base_pos;
  int          sweep_ptr;
  logic [31:0] cover_end;
  logic        cover_hit;
  logic        mask_n;
  nrm_result_t masked_q [$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic void restart_sweep();
    sweep_ptr = 0;
    cover_end = '0;
    cover_hit = 1'b0;
  endfunction

  function automatic void step_position();
    if (base_pos != 32'hFFFF_FFFF) base_pos++;
  endfunction

  // applies one input item to the tracked state and returns its result
  function automatic nrm_result_t predict_masking(logic [1:0] mode, logic [31:0] rs,
                                                  logic [31:0] re, logic [7:0] c);
    nrm_result_t r;
    logic [31:0] ns, ne;
    logic [7:0]  nb;
    logic        is_base, hit;
    int          lo, hi, gone, k;
    r = '0;
    case (mode)
      MODE_NEW_SEQ: begin
        tbl_count = 0;
        base_pos  = '0;
        restart_sweep();
      end
      MODE_REGION: begin
        // reversed region covers nothing and is ignored
        if (rs <= re) begin
          lo = 0;
          while (lo < tbl_count && tbl_end[lo] < rs) lo++;
          hi = lo;
          while (hi < tbl_count && tbl_start[hi] <= re) hi++;
          if (lo < hi) begin
            // merge every overlapped range into slot lo, close the gap
            ns   = (tbl_start[lo] < rs) ? tbl_start[lo] : rs;
            ne   = (tbl_end[hi-1] > re) ? tbl_end[hi-1] : re;
            gone = hi - lo - 1;
            tbl_start[lo] = ns;
            tbl_end[lo]   = ne;
            for (k = lo + 1; k + gone < tbl_count; k++) begin
              tbl_start[k] = tbl_start[k+gone];
              tbl_end[k]   = tbl_end[k+gone];
            end
            tbl_count -= gone;
            restart_sweep();
          end else if (tbl_count >= TABLE_DEPTH) begin
            r.region_dropped = 1'b1;
          end else begin
            for (k = tbl_count; k > lo; k--) begin
              tbl_start[k] = tbl_start[k-1];
              tbl_end[k]   = tbl_end[k-1];
            end
            tbl_start[lo] = rs;
            tbl_end[lo]   = re;
            tbl_count++;
            restart_sweep();
          end
        end
      end
      MODE_BYTE: begin
        r.out_byte = c;
        case (c) inside
          CH_A_UP, CH_A_LO, CH_C_UP, CH_C_LO,
          CH_G_UP, CH_G_LO, CH_T_UP, CH_T_LO: is_base = 1'b1;
          default: is_base = 1'b0;
        endcase
        if (is_base) begin
          hit = 1'b0;
          if (cover_hit && base_pos <= cover_end) begin
            hit = 1'b1;
          end else begin
            cover_hit = 1'b0;
            while (sweep_ptr < tbl_count && tbl_end[sweep_ptr] < base_pos) sweep_ptr++;
            if (sweep_ptr < tbl_count && tbl_start[sweep_ptr] <= base_pos) begin
              cover_hit = 1'b1;
              cover_end = tbl_end[sweep_ptr];
              hit       = 1'b1;
            end
          end
          if (hit) begin
            nb = mask_n ? CH_N_LO
                        : ((c >= CH_A_UP && c <= CH_Z_UP) ? c + CASE_OFFSET : c);
            r.was_masked = (nb != c);
            r.out_byte   = nb;
          end
          step_position();
        end else if (c == CH_N_UP || c == CH_N_LO) begin
          step_position();
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : watch
    nrm_result_t want;
    if (!rst_n) begin
      tbl_count = 0;
      base_pos  = '0;
      restart_sweep();
      mask_n = 1'b0;
      masked_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
          cfg_paddr == CFG_ADDR_MASK_WITH_N)
        mask_n = cfg_pwdata[0];
      if (in_valid && !in_stall) begin
        want = predict_masking(in_mode, in_region_start, in_region_end, in_in_byte);
        masked_q.insert(masked_q.size(), want);
      end
      if (out_valid && !out_stall) begin
        if (masked_q.size() == 0) begin
          $display("%0t: result item with none expected: expected none, actual %h/%b/%b",
                   $time, out_out_byte, out_was_masked, out_region_dropped);
          fail_count++;
        end else begin
          want = masked_q.pop_front();
          if (out_out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                     out_out_byte);
            fail_count++;
          end
          if (out_was_masked !== want.was_masked) begin
            $display("%0t: was_masked expected %b actual %b", $time, want.was_masked,
                     out_was_masked);
            fail_count++;
          end
          if (out_region_dropped !== want.region_dropped) begin
            $display("%0t: region_dropped expected %b actual %b", $time,
                     want.region_dropped, out_region_dropped);
            fail_count++;
          end
        end
      end
    end
    pending <= masked_q.size();
  end

endmodule

// ----- test/tb_nucleotide_region_masker_unit.sv -----
`timescale 1ns / 100ps
// stimulus and verdict for nucleotide_region_masker_unit
// depends on nrm_pkg, the block itself and nrm_mask_checker
module tb_nucleotide_region_masker_unit;
  import nrm_pkg::*;

  // mode 3 is unused by the block, it must answer with an all-zero result
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         TABLE_SLOTS = NRM_MAX_REGIONS_DEF;
  localparam int         SETTLE_CYCLES = 8;
  localparam int         LONG_HOLD = 400;
  localparam logic [7:0] BASES [8] = '{CH_A_UP, CH_C_UP, CH_G_UP, CH_T_UP,
                                       CH_A_LO, CH_C_LO, CH_G_LO, CH_T_LO};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_mode = MODE_NEW_SEQ;
  logic [31:0] in_region_start = '0;
  logic [31:0] in_region_end = '0;
  logic [7:0]  in_in_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_out_byte;
  logic        out_was_masked;
  logic        out_region_dropped;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending;
  int items_sent = 0;
  bit feed_quiet = 1'b0;   // sender offers back to back while set
  bit sink_quiet = 1'b0;   // receiver does not stall while set, but for a requested long hold
  bit hold_req = 1'b0;     // asks the receiver for one long stall

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nucleotide_region_masker_unit uut (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_mode, .in_region_start, .in_region_end, .in_in_byte,
    .out_valid, .out_stall, .out_out_byte, .out_was_masked, .out_region_dropped,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata,
    .cfg_pready
  );

  nrm_mask_checker u_check (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_mode, .in_region_start, .in_region_end, .in_in_byte,
    .out_valid, .out_stall, .out_out_byte, .out_was_masked, .out_region_dropped,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending
  );

  // offer one item after a random gap, return once it is taken
  task automatic send_item(logic [1:0] mode, logic [31:0] rs, logic [31:0] re,
                           logic [7:0] b);
    int gap;
    gap = feed_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_mode         <= mode;
    in_region_start <= rs;
    in_region_end   <= re;
    in_in_byte      <= b;
    do @(posedge clk); while (in_stall);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_cfg(logic [1:0] addr, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // stop offering and wait until every expected result item is out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly bases, some N/n, some arbitrary bytes
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return BASES[$urandom_range(0, 7)];
    if (r < 17) return (r == 15) ? CH_N_UP : CH_N_LO;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_rand_region();
    logic [31:0] s, e;
    case ($urandom_range(0, 9))
      0: begin            // anywhere in the 32-bit space, often reversed
        s = $urandom;
        e = $urandom;
      end
      1: begin            // reversed near the sequence
        e = $urandom_range(0, 40);
        s = e + $urandom_range(1, 5);
      end
      default: begin
        s = $urandom_range(0, 40);
        e = s + $urandom_range(0, 12);
      end
    endcase
    send_item(MODE_REGION, s, e, 8'($urandom));
  endtask

  // usually a new sequence, a few regions, then bytes with an occasional late region or noise
  task automatic send_rand_sequence();
    int nreg, nbyte;
    if ($urandom_range(0, 7) != 0)
      send_item(MODE_NEW_SEQ, $urandom, $urandom, 8'($urandom));
    nreg = $urandom_range(0, 8);
    repeat (nreg) send_rand_region();
    nbyte = $urandom_range(4, 30);
    repeat (nbyte) begin
      case ($urandom_range(0, 19))
        0: send_rand_region();
        1: send_item(MODE_UNUSED, $urandom, $urandom, 8'($urandom));
        default: send_item(MODE_BYTE, $urandom, $urandom, pick_char());
      endcase
    end
    feed_quiet = ($urandom_range(0, 3) == 0);
  endtask

  // loads a full table in shuffled order, overflows it, then frees room by a merge
  task automatic fill_table();
    int order [TABLE_SLOTS];
    int k, j, t;
    for (k = 0; k < TABLE_SLOTS; k++) order[k] = k;
    for (k = TABLE_SLOTS - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    send_item(MODE_NEW_SEQ, '0, '0, '0);
    for (k = 0; k < TABLE_SLOTS; k++)
      send_item(MODE_REGION, 3 * order[k], 3 * order[k] + 1, 8'($urandom));
    // table full: both of these overlap nothing and are dropped
    send_item(MODE_REGION, 32'd300, 32'd301, '0);
    send_item(MODE_REGION, 32'hFFFF_FFF0, 32'hFFFF_FFFF, '0);
    // overlaps three stored ranges, always fits, leaves room for one more
    send_item(MODE_REGION, 32'd4, 32'd10, '0);
    send_item(MODE_REGION, 32'd400, 32'd400, '0);
    repeat (40) send_item(MODE_BYTE, $urandom, $urandom, pick_char());
  endtask

  // receiver: random stall before each item, quiet stretches, one long hold on request
  initial begin : result_sink
    int n, taken;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken % 16 == 0) sink_quiet = ($urandom_range(0, 3) == 0);
      if (hold_req) begin
        n = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        n = sink_quiet ? 0 : $urandom_range(0, 11);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin : stimulus
    int phase, goal;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, lower-case masking
    write_cfg(CFG_ADDR_MASK_WITH_N, 32'h0);
    send_item(MODE_NEW_SEQ, '1, '1, '1);
    send_item(MODE_REGION, 32'd2, 32'd4, '0);
    send_item(MODE_REGION, 32'd3, 32'd6, '0);          // overlap merges to 2..6
    send_item(MODE_REGION, 32'd7, 32'd7, '0);          // touches 2..6, stays separate
    send_item(MODE_REGION, 32'd10, 32'd5, '0);         // reversed, ignored
    send_item(MODE_REGION, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0);
    send_item(MODE_REGION, 32'd20, 32'hFFFF_FFFF, '0); // swallows the one above
    send_item(MODE_BYTE, '0, '0, CH_A_UP);             // position 0, not covered
    send_item(MODE_BYTE, '0, '0, 8'h78);               // not a base, no advance
    send_item(MODE_BYTE, '1, '1, CH_C_LO);             // position 1
    send_item(MODE_BYTE, '0, '0, CH_A_UP);             // position 2, masked
    send_item(MODE_BYTE, '0, '0, CH_C_LO);             // covered but already lower case
    send_item(MODE_BYTE, '0, '0, CH_N_UP);             // advances only
    send_item(MODE_BYTE, '0, '0, CH_G_UP);
    send_item(MODE_BYTE, '0, '0, CH_T_UP);
    send_item(MODE_BYTE, '0, '0, CH_T_LO);             // adjacent range
    send_item(MODE_BYTE, '0, '0, CH_G_UP);             // position 8, not covered
    send_item(MODE_REGION, 32'd9, 32'd12, '0);         // load in mid-sequence
    send_item(MODE_BYTE, '0, '0, CH_C_UP);             // position 9, masked
    send_item(MODE_UNUSED, '1, '1, '1);
    send_item(MODE_BYTE, '0, '0, 8'hFF);
    send_item(MODE_BYTE, '0, '0, 8'h00);
    send_item(MODE_NEW_SEQ, '0, '0, '0);
    send_item(MODE_BYTE, '0, '0, CH_A_UP);             // table cleared

    // random phases, alternating the masking style
    for (phase = 0; phase < 6; phase++) begin
      settle();
      write_cfg(CFG_ADDR_MASK_WITH_N, (phase % 2 == 0) ? 32'h1 : 32'h0);
      if (phase == 2) fill_table();
      if (phase == 3) begin
        // receiver goes silent while the sender keeps pushing
        feed_quiet = 1'b1;
        hold_req   = 1'b1;
      end
      goal = items_sent + 70;
      while (items_sent < goal) send_rand_sequence();
    end

    settle();
    if (fail_count == 0) begin
      $display("[nucleotide_region_masker_unit] OK");
    end else begin
      $display("[nucleotide_region_masker_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("[nucleotide_region_masker_unit] ERROR");
    $finish;
  end

endmodule
